@@ sv/calu_pkg.sv @@
// Shared operation codes, flag positions and stage word types for the flag ALU.
package calu_pkg;

    localparam int unsigned OP_W = 5;

    localparam logic [OP_W-1:0] OP_ADD   = 5'd0;
    localparam logic [OP_W-1:0] OP_ADC   = 5'd1;
    localparam logic [OP_W-1:0] OP_SUB   = 5'd2;
    localparam logic [OP_W-1:0] OP_SBC   = 5'd3;
    localparam logic [OP_W-1:0] OP_AND   = 5'd4;
    localparam logic [OP_W-1:0] OP_XOR   = 5'd5;
    localparam logic [OP_W-1:0] OP_OR    = 5'd6;
    localparam logic [OP_W-1:0] OP_CP    = 5'd7;
    localparam logic [OP_W-1:0] OP_INC   = 5'd8;
    localparam logic [OP_W-1:0] OP_DEC   = 5'd9;
    localparam logic [OP_W-1:0] OP_RLCA  = 5'd10;
    localparam logic [OP_W-1:0] OP_RRCA  = 5'd11;
    localparam logic [OP_W-1:0] OP_RLA   = 5'd12;
    localparam logic [OP_W-1:0] OP_RRA   = 5'd13;
    localparam logic [OP_W-1:0] OP_RLC   = 5'd14;
    localparam logic [OP_W-1:0] OP_RRC   = 5'd15;
    localparam logic [OP_W-1:0] OP_RL    = 5'd16;
    localparam logic [OP_W-1:0] OP_RR    = 5'd17;
    localparam logic [OP_W-1:0] OP_SLA   = 5'd18;
    localparam logic [OP_W-1:0] OP_SRA   = 5'd19;
    localparam logic [OP_W-1:0] OP_SRL   = 5'd20;
    localparam logic [OP_W-1:0] OP_SWAP  = 5'd21;
    localparam logic [OP_W-1:0] OP_BIT   = 5'd22;
    localparam logic [OP_W-1:0] OP_SET   = 5'd23;
    localparam logic [OP_W-1:0] OP_RES   = 5'd24;
    localparam logic [OP_W-1:0] OP_DAA   = 5'd25;
    localparam logic [OP_W-1:0] OP_CPL   = 5'd26;
    localparam logic [OP_W-1:0] OP_SCF   = 5'd27;
    localparam logic [OP_W-1:0] OP_CCF   = 5'd28;
    localparam logic [OP_W-1:0] OP_ADD16 = 5'd29;
    localparam logic [OP_W-1:0] OP_ADDSP = 5'd30;

    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    localparam logic [7:0] DAA_LIMIT  = 8'h99;
    localparam logic [3:0] DAA_DIGIT  = 4'h9;
    localparam logic [7:0] DAA_CORR_L = 8'h06;
    localparam logic [7:0] DAA_CORR_H = 8'h60;

    // decode stage word
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [15:0]     a;
        logic [15:0]     b;
        logic [3:0]      f;
        logic            cin;
        logic            h;
        logic [7:0]      mask;
        logic [7:0]      daa_corr;
        logic            daa_c;
    } s1_t;

    // execute stage word
    typedef struct packed {
        logic [15:0] res;
        logic [7:0]  zbyte;
        logic        zuse;
        logic        zalt;
        logic        n;
        logic        h;
        logic        c;
    } s2_t;

endpackage

@@ sv/calu_decode.sv @@
// First stage: operand capture, carry-in, half carry, bit mask and decimal adjust correction.
module calu_decode
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [calu_pkg::OP_W-1:0] op,
    input  logic [15:0]               a,
    input  logic [15:0]               b,
    input  logic [2:0]                bi,
    input  logic [3:0]                f,
    output logic                      out_valid,
    input  logic                      out_ready,
    output calu_pkg::s1_t             out_word
);

    logic          valid_reg;
    logic          valid_next;
    calu_pkg::s1_t word_reg;
    calu_pkg::s1_t word_next;
    logic [4:0]    nib_add;
    logic [4:0]    nib_sub;
    logic [12:0]   sum12;
    logic          neg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_comb
    begin
        word_next      = '0;
        word_next.op   = op;
        word_next.a    = a;
        word_next.b    = b;
        word_next.f    = f;
        word_next.cin  = ((op == calu_pkg::OP_ADC) || (op == calu_pkg::OP_SBC))
                         ? f[calu_pkg::FLAG_C] : 1'b0;
        word_next.mask = 8'(1) << bi;

        nib_add = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, word_next.cin};
        nib_sub = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, word_next.cin};
        sum12   = {1'b0, a[11:0]} + {1'b0, b[11:0]};

        case (op)
            calu_pkg::OP_ADD, calu_pkg::OP_ADC, calu_pkg::OP_ADDSP:
                word_next.h = nib_add[4];
            calu_pkg::OP_SUB, calu_pkg::OP_SBC, calu_pkg::OP_CP:
                word_next.h = nib_sub[4];
            calu_pkg::OP_INC:
                word_next.h = (a[3:0] == 4'hF);
            calu_pkg::OP_DEC:
                word_next.h = (a[3:0] == 4'h0);
            calu_pkg::OP_ADD16:
                word_next.h = sum12[12];
            default:
                word_next.h = 1'b0;
        endcase

        neg = f[calu_pkg::FLAG_N];
        if (f[calu_pkg::FLAG_H] || (!neg && (a[3:0] > calu_pkg::DAA_DIGIT)))
        begin
            word_next.daa_corr = word_next.daa_corr | calu_pkg::DAA_CORR_L;
        end
        if (f[calu_pkg::FLAG_C] || (!neg && (a[7:0] > calu_pkg::DAA_LIMIT)))
        begin
            word_next.daa_corr = word_next.daa_corr | calu_pkg::DAA_CORR_H;
            word_next.daa_c    = 1'b1;
        end
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= word_next;
        end
    end

endmodule

@@ sv/calu_exec.sv @@
// Second stage: result and N/H/C flags per operation, zero source selection.
module calu_exec
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  calu_pkg::s1_t in_word,
    output logic          out_valid,
    input  logic          out_ready,
    output calu_pkg::s2_t out_word
);

    logic          valid_reg;
    logic          valid_next;
    calu_pkg::s2_t word_reg;
    calu_pkg::s2_t word_next;
    logic [7:0]    a8;
    logic [7:0]    b8;
    logic          fz;
    logic          fc;
    logic [8:0]    add9;
    logic [8:0]    sub9;
    logic [16:0]   add17;
    logic [8:0]    sp9;
    logic [7:0]    r8;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_comb
    begin
        a8    = in_word.a[7:0];
        b8    = in_word.b[7:0];
        fz    = in_word.f[calu_pkg::FLAG_Z];
        fc    = in_word.f[calu_pkg::FLAG_C];
        add9  = {1'b0, a8} + {1'b0, b8} + {8'b0, in_word.cin};
        sub9  = {1'b0, a8} - {1'b0, b8} - {8'b0, in_word.cin};
        add17 = {1'b0, in_word.a} + {1'b0, in_word.b};
        sp9   = {1'b0, a8} + {1'b0, b8};
        r8    = a8;

        word_next      = '0;
        word_next.zuse = 1'b1;
        word_next.h    = in_word.h;

        case (in_word.op)
            calu_pkg::OP_ADD, calu_pkg::OP_ADC:
            begin
                r8          = add9[7:0];
                word_next.c = add9[8];
            end
            calu_pkg::OP_SUB, calu_pkg::OP_SBC:
            begin
                r8          = sub9[7:0];
                word_next.n = 1'b1;
                word_next.c = sub9[8];
            end
            calu_pkg::OP_CP:
            begin
                word_next.zbyte = sub9[7:0];
                word_next.zuse  = 1'b0;
                word_next.zalt  = (sub9[7:0] == 8'h00);
                word_next.n     = 1'b1;
                word_next.c     = sub9[8];
            end
            calu_pkg::OP_AND:
            begin
                r8          = a8 & b8;
                word_next.h = 1'b1;
            end
            calu_pkg::OP_XOR:
                r8 = a8 ^ b8;
            calu_pkg::OP_OR:
                r8 = a8 | b8;
            calu_pkg::OP_INC:
            begin
                r8          = a8 + 8'd1;
                word_next.c = fc;
            end
            calu_pkg::OP_DEC:
            begin
                r8          = a8 - 8'd1;
                word_next.n = 1'b1;
                word_next.c = fc;
            end
            calu_pkg::OP_RLCA, calu_pkg::OP_RLC:
            begin
                r8             = {a8[6:0], a8[7]};
                word_next.c    = a8[7];
                word_next.zuse = (in_word.op == calu_pkg::OP_RLC);
            end
            calu_pkg::OP_RRCA, calu_pkg::OP_RRC:
            begin
                r8             = {a8[0], a8[7:1]};
                word_next.c    = a8[0];
                word_next.zuse = (in_word.op == calu_pkg::OP_RRC);
            end
            calu_pkg::OP_RLA, calu_pkg::OP_RL:
            begin
                r8             = {a8[6:0], fc};
                word_next.c    = a8[7];
                word_next.zuse = (in_word.op == calu_pkg::OP_RL);
            end
            calu_pkg::OP_RRA, calu_pkg::OP_RR:
            begin
                r8             = {fc, a8[7:1]};
                word_next.c    = a8[0];
                word_next.zuse = (in_word.op == calu_pkg::OP_RR);
            end
            calu_pkg::OP_SLA:
            begin
                r8          = {a8[6:0], 1'b0};
                word_next.c = a8[7];
            end
            calu_pkg::OP_SRA:
            begin
                r8          = {a8[7], a8[7:1]};
                word_next.c = a8[0];
            end
            calu_pkg::OP_SRL:
            begin
                r8          = {1'b0, a8[7:1]};
                word_next.c = a8[0];
            end
            calu_pkg::OP_SWAP:
                r8 = {a8[3:0], a8[7:4]};
            calu_pkg::OP_BIT:
            begin
                word_next.zuse = 1'b0;
                word_next.zalt = ((a8 & in_word.mask) == 8'h00);
                word_next.h    = 1'b1;
                word_next.c    = fc;
            end
            calu_pkg::OP_SET, calu_pkg::OP_RES:
            begin
                r8 = (in_word.op == calu_pkg::OP_SET) ? (a8 | in_word.mask)
                                                       : (a8 & ~in_word.mask);
                word_next.zuse = 1'b0;
                word_next.zalt = fz;
                word_next.n    = in_word.f[calu_pkg::FLAG_N];
                word_next.h    = in_word.f[calu_pkg::FLAG_H];
                word_next.c    = fc;
            end
            calu_pkg::OP_DAA:
            begin
                r8 = in_word.f[calu_pkg::FLAG_N] ? (a8 - in_word.daa_corr)
                                                  : (a8 + in_word.daa_corr);
                word_next.n = in_word.f[calu_pkg::FLAG_N];
                word_next.c = in_word.daa_c;
            end
            calu_pkg::OP_CPL:
            begin
                r8             = ~a8;
                word_next.zuse = 1'b0;
                word_next.zalt = fz;
                word_next.n    = 1'b1;
                word_next.h    = 1'b1;
                word_next.c    = fc;
            end
            calu_pkg::OP_SCF, calu_pkg::OP_CCF:
            begin
                word_next.zuse = 1'b0;
                word_next.zalt = fz;
                word_next.c    = (in_word.op == calu_pkg::OP_SCF) ? 1'b1 : !fc;
            end
            default:
            begin
                word_next.zuse = 1'b0;
            end
        endcase

        word_next.res = {8'h00, r8};
        if (word_next.zuse)
        begin
            word_next.zbyte = r8;
        end

        case (in_word.op)
            calu_pkg::OP_ADD16:
            begin
                word_next.res  = add17[15:0];
                word_next.zalt = fz;
                word_next.c    = add17[16];
            end
            calu_pkg::OP_ADDSP:
            begin
                word_next.res = in_word.a + {{8{b8[7]}}, b8};
                word_next.c   = sp9[8];
            end
            calu_pkg::OP_CP, calu_pkg::OP_BIT:
                word_next.res = {8'h00, a8};
            default:
            begin
                if (in_word.op > calu_pkg::OP_ADDSP)
                begin
                    // unused code: word and flags pass through
                    word_next.res  = in_word.a;
                    word_next.zalt = fz;
                    word_next.n    = in_word.f[calu_pkg::FLAG_N];
                    word_next.h    = in_word.f[calu_pkg::FLAG_H];
                    word_next.c    = fc;
                end
            end
        endcase
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= word_next;
        end
    end

endmodule

@@ sv/calu_flags.sv @@
// Third stage: zero detect, flag assembly and output register.
module calu_flags
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  calu_pkg::s2_t in_word,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [15:0]   result,
    output logic [3:0]    flags
);

    logic        valid_reg;
    logic        valid_next;
    logic [15:0] result_reg;
    logic [3:0]  flags_reg;
    logic [3:0]  flags_next;
    logic        z;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign result    = result_reg;
    assign flags     = flags_reg;

    always_comb
    begin
        z          = in_word.zuse ? (in_word.zbyte == 8'h00) : in_word.zalt;
        flags_next = '0;
        flags_next[calu_pkg::FLAG_Z] = z;
        flags_next[calu_pkg::FLAG_N] = in_word.n;
        flags_next[calu_pkg::FLAG_H] = in_word.h;
        flags_next[calu_pkg::FLAG_C] = in_word.c;
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            result_reg <= in_word.res;
            flags_reg  <= flags_next;
        end
    end

endmodule

@@ sv/cpu_alu_with_flags.sv @@
// Top level: three-stage pipelined 8/16-bit ALU with Z/N/H/C flags.
//
//  word      | direction | handshake             | payload
//  ----------+-----------+-----------------------+----------------------------------------
//  request   | in        | req_valid / req_ready | req_type, operand_a, operand_b,
//            |           |                       | bit_index, flags_in
//  response  | out       | res_valid / res_ready | result_value, flags_out
//
// res_valid rises once an accepted word has passed the decode, execute and flag registers.
// One word per cycle sustained while res_ready stays high. Stages: decode (half carry, mask,
// DAA correction), execute, flag assembly.
// Reset clears the stage valid bits only; the pipeline is empty after reset.
// A stall on res_ready backs up stage by stage; each stage holds its word until taken.
module cpu_alu_with_flags
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  logic [calu_pkg::OP_W-1:0] req_type,
    input  logic [15:0]               operand_a,
    input  logic [15:0]               operand_b,
    input  logic [2:0]                bit_index,
    input  logic [3:0]                flags_in,
    output logic                      res_valid,
    input  logic                      res_ready,
    output logic [15:0]               result_value,
    output logic [3:0]                flags_out
);

    logic          s1_valid;
    logic          s1_ready;
    calu_pkg::s1_t s1_word;
    logic          s2_valid;
    logic          s2_ready;
    calu_pkg::s2_t s2_word;

    calu_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_valid),
        .in_ready  (req_ready),
        .op        (req_type),
        .a         (operand_a),
        .b         (operand_b),
        .bi        (bit_index),
        .f         (flags_in),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_word  (s1_word)
    );

    calu_exec u_exec
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_word   (s1_word),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_word  (s2_word)
    );

    calu_flags u_flags
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_word   (s2_word),
        .out_valid (res_valid),
        .out_ready (res_ready),
        .result    (result_value),
        .flags     (flags_out)
    );

endmodule
